### src/sbus_frame_decoder_macros.svh
// assertion macros for the sbus frame decoder checker
// expects signals clk and rst in the scope of each use
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// checked only outside reset
`define SFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked during reset too
`define SFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/sbusfd_pkg.sv
// shared types and constants for the sbus frame decoder
// no dependencies
package sbusfd_pkg;

  localparam int ANALOG_CHANNELS_DEF = 16;
  localparam int CHANNEL_BITS_DEF    = 11;
  localparam int FRAME_BYTES_DEF     = 25;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 11;
  localparam int INDEX_W = 5;
  localparam int TDATA_W = 16;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 1'd1;

  localparam logic [BYTE_W-1:0]  HEADER_RST = 8'h0F;
  localparam logic [BYTE_W-1:0]  FOOTER_RST = 8'h00;
  localparam logic [VALUE_W-1:0] DIGITAL_ON = 11'h7FF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PACK_RD,
    ST_PACK_WR,
    ST_PACK_SPILL,
    ST_DIG_LO,
    ST_DIG_HI,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

endpackage

### src/sbusfd_store.sv
// channel store: one synchronous memory, one write and one read port
// per-entry valid bits make an unwritten entry read as zero; uses sbusfd_pkg
module sbusfd_store import sbusfd_pkg::*; #(
  parameter int DEPTH  = ANALOG_CHANNELS_DEF + 2,
  parameter int ADDR_W = $clog2(ANALOG_CHANNELS_DEF + 2)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clr,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  logic [VALUE_W-1:0] rd_q;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[raddr];
      if (we) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

### src/sbus_frame_decoder.sv
// sbus frame decoder top level: byte sequencer around the channel store
// depends on sbusfd_pkg and sbusfd_store
//
// usage:
//   s_* takes received bytes, one per transfer. outside a frame a byte equal
//   to the header register opens a frame and clears the channel store; later
//   bytes are packed lsb first into the proportional channels, the byte before
//   last sets the two digital channels, and a final byte equal to the footer
//   register sends all channels on m_* as one run, tlast on the final one.
//   a wrong final byte drops the frame.
//   cfg_wen/cfg_index/cfg_data write header (0) and footer (1); writing them
//   only while idle is up to the user, as the decoder has no check for it.
// steps:
//   header and ignored bytes need only idle; a data byte adds a store read, a
//   modify/write and, on a spill, a write into the next channel; the digital byte
//   sets both digital channels; a good footer reads and loads each channel in turn.
// reset: registers return to 0x0F/0x00 and the decoder waits for a header.
// stall: a low m_tready holds the run; bytes are taken again once the last
//   channel sits in the output register.
module sbus_frame_decoder import sbusfd_pkg::*; #(
  parameter int ANALOG_CHANNELS = ANALOG_CHANNELS_DEF,
  parameter int CHANNEL_BITS    = CHANNEL_BITS_DEF,
  parameter int FRAME_BYTES     = FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,   // [4:0] channel_index, [15:5] channel_value
  output logic                 m_tlast,   // last_channel
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int ALL_CHANNELS = ANALOG_CHANNELS + 2;
  localparam int ADDR_W = $clog2(ALL_CHANNELS);
  localparam int POS_W  = $clog2(FRAME_BYTES);
  localparam int SH_W   = $clog2(CHANNEL_BITS);
  localparam int SUM_W  = SH_W + 1;
  localparam int SHF_W  = CHANNEL_BITS + BYTE_W;

  state_t state, state_next;

  logic [POS_W-1:0]   pos;
  logic [ADDR_W-1:0]  ch;
  logic [SH_W-1:0]    sh;
  logic [ADDR_W-1:0]  k;
  logic [BYTE_W-1:0]  byte_q;
  logic [VALUE_W-1:0] spill_q;
  logic [BYTE_W-1:0]  header_q;
  logic [BYTE_W-1:0]  footer_q;

  logic               in_fire;
  logic               out_free;
  logic               pos_data;
  logic               pos_dig;
  logic               hdr_hit;
  logic               ch_live;
  logic               wrap;
  logic               spill_go;
  logic [SUM_W-1:0]   sum;
  logic [SHF_W-1:0]   shifted;

  logic               mem_clr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;
  logic               emit_load;

  sbusfd_store #(
    .DEPTH  (ALL_CHANNELS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .clr   (mem_clr),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign pos_data = (pos != '0) && (pos < POS_W'(FRAME_BYTES - 2));
  assign pos_dig  = (pos == POS_W'(FRAME_BYTES - 2));
  assign hdr_hit  = (pos == '0) && (s_tdata == header_q);

  assign shifted  = SHF_W'(byte_q) << sh;
  assign sum      = SUM_W'(sh) + SUM_W'(BYTE_W);
  assign wrap     = (sum >= SUM_W'(CHANNEL_BITS));
  assign ch_live  = (ch < ADDR_W'(ANALOG_CHANNELS));
  assign spill_go = (sum > SUM_W'(CHANNEL_BITS)) && (ch < ADDR_W'(ANALOG_CHANNELS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (pos != '0)) begin
          if (pos_data) begin
            state_next = ST_PACK_RD;
          end else if (pos_dig) begin
            state_next = ST_DIG_LO;
          end else if (s_tdata == footer_q) begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_PACK_RD:    state_next = ST_PACK_WR;
      ST_PACK_WR:    state_next = spill_go ? ST_PACK_SPILL : ST_IDLE;
      ST_PACK_SPILL: state_next = ST_IDLE;
      ST_DIG_LO:     state_next = ST_DIG_HI;
      ST_DIG_HI:     state_next = ST_IDLE;
      ST_EMIT_RD:    state_next = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (out_free) begin
          state_next = (k == ADDR_W'(ALL_CHANNELS - 1)) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // store access and output load
  always_comb begin
    mem_clr   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ch;
    mem_wdata = '0;
    mem_raddr = ch;
    emit_load = 1'b0;
    case (state)
      ST_IDLE: begin
        mem_clr = in_fire && hdr_hit;
      end
      ST_PACK_WR: begin
        mem_we    = ch_live;
        mem_wdata = mem_rdata | VALUE_W'(shifted[CHANNEL_BITS-1:0]);
      end
      ST_PACK_SPILL: begin
        mem_we    = 1'b1;
        mem_wdata = spill_q;
      end
      ST_DIG_LO: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(ANALOG_CHANNELS);
        mem_wdata = byte_q[0] ? DIGITAL_ON : '0;
      end
      ST_DIG_HI: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(ANALOG_CHANNELS + 1);
        mem_wdata = byte_q[1] ? DIGITAL_ON : '0;
      end
      ST_EMIT_RD: begin
        mem_raddr = k;
      end
      ST_EMIT_WR: begin
        mem_raddr = k;
        emit_load = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pos      <= '0;
      ch       <= '0;
      sh       <= '0;
      k        <= '0;
      header_q <= HEADER_RST;
      footer_q <= FOOTER_RST;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        case (cfg_index)
          REG_HEADER: header_q <= cfg_data;
          REG_FOOTER: footer_q <= cfg_data;
          default:    header_q <= header_q;
        endcase
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (pos == '0) begin
              if (hdr_hit) begin
                pos <= POS_W'(1);
                ch  <= '0;
                sh  <= '0;
              end
            end else if (pos_data || pos_dig) begin
              pos <= pos + POS_W'(1);
            end else begin
              pos <= '0;
              ch  <= '0;
              sh  <= '0;
              k   <= '0;
            end
          end
        end
        ST_PACK_WR: begin
          if (wrap) begin
            sh <= SH_W'(sum - SUM_W'(CHANNEL_BITS));
            if (ch_live) begin
              ch <= ch + ADDR_W'(1);
            end
          end else begin
            sh <= SH_W'(sum);
          end
        end
        ST_EMIT_WR: begin
          if (out_free) begin
            k <= k + ADDR_W'(1);
          end
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_q <= s_tdata;
    end
    if (state == ST_PACK_WR) begin
      spill_q <= VALUE_W'(shifted[SHF_W-1:CHANNEL_BITS]);
    end
    if (emit_load) begin
      m_tdata <= {mem_rdata, INDEX_W'(k)};
      m_tlast <= (k == ADDR_W'(ALL_CHANNELS - 1));
    end
  end

endmodule

### src/sbusfd_checker.sv
// port-level checker for the sbus frame decoder, bound to the top level
// depends on sbusfd_pkg and sbus_frame_decoder_macros.svh
`include "sbus_frame_decoder_macros.svh"

module sbusfd_checker import sbusfd_pkg::*; #(
  parameter int ANALOG_CHANNELS = ANALOG_CHANNELS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast
);

  logic [INDEX_W-1:0] idx;
  assign idx = m_tdata[INDEX_W-1:0];

  `SFD_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "stalled transfer dropped")
  `SFD_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "stalled payload changed")
  `SFD_ASSERT(a_last_mark, m_tvalid |-> (m_tlast == (idx == INDEX_W'(ANALOG_CHANNELS + 1))), "tlast not on final channel")
  `SFD_ASSERT(a_idx_range, m_tvalid |-> (idx <= INDEX_W'(ANALOG_CHANNELS + 1)), "channel index out of range")
  `SFD_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind sbus_frame_decoder sbusfd_checker #(
  .ANALOG_CHANNELS (ANALOG_CHANNELS)
) u_sbusfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
